@@ hdl/sctok_pkg.sv @@
// shared types, constants and character classes for the source code tokenizer
`timescale 1ns / 1ps
`default_nettype none

package sctok_pkg;

    // payload widths
    localparam int TEXT_BYTE_W  = 8;
    localparam int KIND_W       = 3;
    localparam int COUNT_W      = 32;
    localparam int QUOTE_W      = 2;
    localparam int MAX_RESULTS  = 4;

    // configuration port
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_SKIP_BLANK = 1'b0;

    // token kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WS      = 3'd0,
        KIND_NL      = 3'd1,
        KIND_COMMENT = 3'd2,
        KIND_IDENT   = 3'd3,
        KIND_NUM     = 3'd4,
        KIND_STRING  = 3'd5,
        KIND_SYMBOL  = 3'd6
    } tok_kind_t;

    // quote codes
    localparam logic [QUOTE_W-1:0] QUOTE_NONE     = 2'd0;
    localparam logic [QUOTE_W-1:0] QUOTE_SINGLE   = 2'd1;
    localparam logic [QUOTE_W-1:0] QUOTE_DOUBLE   = 2'd2;
    localparam logic [QUOTE_W-1:0] QUOTE_BACKTICK = 2'd3;

    // characters
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_VT};
    endfunction

    function automatic logic ident_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER) || (c >= CH_HIGH);
    endfunction

    function automatic logic ident_cont(input logic [7:0] c);
        return ident_start(c) || is_digit(c);
    endfunction

    function automatic logic num_cont(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT);
    endfunction

    function automatic logic [QUOTE_W-1:0] quote_code(input logic [7:0] c);
        logic [QUOTE_W-1:0] q;
        case (c)
            CH_SQUOTE: q = QUOTE_SINGLE;
            CH_DQUOTE: q = QUOTE_DOUBLE;
            CH_BTICK:  q = QUOTE_BACKTICK;
            default:   q = QUOTE_NONE;
        endcase
        return q;
    endfunction

    function automatic logic [7:0] quote_char(input logic [QUOTE_W-1:0] q);
        logic [7:0] c;
        case (q)
            QUOTE_SINGLE: c = CH_SQUOTE;
            QUOTE_DOUBLE: c = CH_DQUOTE;
            default:      c = CH_BTICK;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/sctok_byte_if.sv @@
// text byte channel
`timescale 1ns / 1ps
`default_nettype none

interface sctok_byte_if;
    logic                                valid;
    logic                                ready;
    logic [sctok_pkg::TEXT_BYTE_W-1:0]   text_byte;
    logic                                final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/sctok_token_if.sv @@
// token result channel
`timescale 1ns / 1ps
`default_nettype none

interface sctok_token_if;
    logic                            valid;
    logic                            ready;
    logic [sctok_pkg::KIND_W-1:0]    token_kind;
    logic [sctok_pkg::COUNT_W-1:0]   token_offset;
    logic [sctok_pkg::COUNT_W-1:0]   token_length;
    logic                            is_triplet;
    logic [sctok_pkg::QUOTE_W-1:0]   quote_kind;
    logic                            is_broken;
    logic [sctok_pkg::COUNT_W-1:0]   token_number;
    logic                            text_done;
    logic                            last_of_run;

    modport source (
        output valid, output token_kind, output token_offset, output token_length,
        output is_triplet, output quote_kind, output is_broken, output token_number,
        output text_done, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_offset, input token_length,
        input is_triplet, input quote_kind, input is_broken, input token_number,
        input text_done, input last_of_run, output ready
    );
endinterface

`default_nettype wire

@@ hdl/source_code_tokenizer_unit.sv @@
// top level of the streaming source code tokenizer
//
//  channel    dir  handshake       payload
//  byte_in    in   valid/ready     text_byte, final_byte
//  token_out  out  valid/ready     kind, offset, length, quote info, number, flags
//  apb        in   psel/penable    skip_blank_tokens at address 0
//
// an accepted byte lexes the oldest held byte once two are held; the lexer runs two bytes
// behind the input; a final byte lexes held bytes and itself and flushes the open token
// results of a byte (up to four) land in a four-entry result buffer, drained one per cycle
// while token_out is ready; input is ready while the buffer is empty or its last entry
// is being taken, so the next byte waits until the results of the last one are taken
// reset is asynchronous, clears lexer state and the buffer, and sets skipping on
`timescale 1ns / 1ps
`default_nettype none

module source_code_tokenizer_unit #(
    parameter int OFFSET_BITS = 32
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    sctok_byte_if.sink                           byte_in,
    sctok_token_if.source                        token_out,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [sctok_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire  [sctok_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sctok_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WS,
        MODE_LINE,
        MODE_BLOCK,
        MODE_IDENT,
        MODE_NUM,
        MODE_TRIPLE,
        MODE_SINGLE,
        MODE_BLOCK_END,
        MODE_TRIPLE_END
    } lex_mode_t;

    typedef logic [OFFSET_BITS-1:0] pos_t;

    typedef struct packed {
        lex_mode_t                        mode;
        logic                             escape;
        logic [sctok_pkg::QUOTE_W-1:0]    quote;
        logic [1:0]                       close_cnt;
        pos_t                             start;
        pos_t                             pos;
    } lex_state_t;

    typedef struct packed {
        logic                             vld;
        sctok_pkg::tok_kind_t             kind;
        pos_t                             start;
        pos_t                             stop;
        logic                             trip;
        logic [sctok_pkg::QUOTE_W-1:0]    qk;
        logic                             broken;
    } emit_t;

    typedef struct packed {
        lex_state_t st;
        emit_t      em0;
        emit_t      em1;
    } lex_out_t;

    typedef struct packed {
        logic [sctok_pkg::KIND_W-1:0]     kind;
        logic [sctok_pkg::COUNT_W-1:0]    offset;
        logic [sctok_pkg::COUNT_W-1:0]    length;
        logic                             trip;
        logic [sctok_pkg::QUOTE_W-1:0]    qk;
        logic                             broken;
        logic [sctok_pkg::COUNT_W-1:0]    number;
        logic                             done;
        logic                             last;
    } res_t;

    localparam int NUM_CAND = 7;
    localparam int RES_CNT_W = $clog2(sctok_pkg::MAX_RESULTS + 1);

    localparam lex_state_t LEX_RESET = '{
        mode: MODE_IDLE, escape: 1'b0, quote: sctok_pkg::QUOTE_NONE,
        close_cnt: 2'd0, start: '0, pos: '0
    };

    // emit record builder
    function automatic emit_t mk_emit(
        input sctok_pkg::tok_kind_t k, input pos_t s, input pos_t e,
        input logic trip, input logic [sctok_pkg::QUOTE_W-1:0] qk, input logic broken
    );
        emit_t r;
        r.vld    = 1'b1;
        r.kind   = k;
        r.start  = s;
        r.stop   = e;
        r.trip   = trip;
        r.qk     = qk;
        r.broken = broken;
        return r;
    endfunction

    // saturate to the 32-bit result fields
    function automatic logic [sctok_pkg::COUNT_W-1:0] clamp32(input pos_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'hFFFF_FFFF) ? '1 : wide[sctok_pkg::COUNT_W-1:0];
    endfunction

    // one lexing step on byte c with n valid lookahead bytes
    function automatic lex_out_t lex_step(
        input lex_state_t s, input logic act, input logic [7:0] c,
        input logic [1:0] n, input logic [7:0] c1, input logic [7:0] c2
    );
        lex_out_t                         r;
        pos_t                             pos;
        pos_t                             after;
        logic                             fresh;
        logic [sctok_pkg::QUOTE_W-1:0]    qk;
        logic [7:0]                       qc;
        r       = '0;
        r.st    = s;
        fresh   = 1'b0;
        pos     = s.pos;
        after   = (pos == '1) ? pos : pos + OFFSET_BITS'(1);
        qk      = sctok_pkg::quote_code(c);
        qc      = sctok_pkg::quote_char(s.quote);
        if (act)
        begin
            if (s.close_cnt != 2'd0)
            begin
                // bytes of an opener or closer are absorbed unconditionally
                r.st.close_cnt = s.close_cnt - 2'd1;
                if (s.close_cnt == 2'd1)
                begin
                    if (s.mode == MODE_BLOCK_END)
                    begin
                        r.em0 = mk_emit(sctok_pkg::KIND_COMMENT, s.start, after, 1'b0,
                                        sctok_pkg::QUOTE_NONE, 1'b0);
                        r.st.mode = MODE_IDLE;
                    end
                    else if (s.mode == MODE_TRIPLE_END)
                    begin
                        r.em0 = mk_emit(sctok_pkg::KIND_STRING, s.start, after, 1'b1,
                                        s.quote, 1'b0);
                        r.st.mode = MODE_IDLE;
                    end
                end
            end
            else
            begin
                case (s.mode)
                    MODE_WS:
                    begin
                        if (!sctok_pkg::is_blank(c))
                        begin
                            r.em0 = mk_emit(sctok_pkg::KIND_WS, s.start, pos, 1'b0,
                                            sctok_pkg::QUOTE_NONE, 1'b0);
                            fresh = 1'b1;
                        end
                    end
                    MODE_LINE:
                    begin
                        if (s.escape)
                        begin
                            r.st.escape = 1'b0;
                        end
                        else if (c == sctok_pkg::CH_NL)
                        begin
                            r.em0 = mk_emit(sctok_pkg::KIND_COMMENT, s.start, pos, 1'b0,
                                            sctok_pkg::QUOTE_NONE, 1'b0);
                            fresh = 1'b1;
                        end
                        else if (c == sctok_pkg::CH_BSLASH)
                        begin
                            r.st.escape = 1'b1;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (c == sctok_pkg::CH_STAR && n >= 2'd1 && c1 == sctok_pkg::CH_SLASH)
                        begin
                            r.st.mode      = MODE_BLOCK_END;
                            r.st.close_cnt = 2'd1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (!sctok_pkg::ident_cont(c))
                        begin
                            r.em0 = mk_emit(sctok_pkg::KIND_IDENT, s.start, pos, 1'b0,
                                            sctok_pkg::QUOTE_NONE, 1'b0);
                            fresh = 1'b1;
                        end
                    end
                    MODE_NUM:
                    begin
                        if (!sctok_pkg::num_cont(c))
                        begin
                            r.em0 = mk_emit(sctok_pkg::KIND_NUM, s.start, pos, 1'b0,
                                            sctok_pkg::QUOTE_NONE, 1'b0);
                            fresh = 1'b1;
                        end
                    end
                    MODE_TRIPLE:
                    begin
                        if (c == qc && n == 2'd2 && c1 == qc && c2 == qc)
                        begin
                            r.st.mode      = MODE_TRIPLE_END;
                            r.st.close_cnt = 2'd2;
                        end
                    end
                    MODE_SINGLE:
                    begin
                        if (c == sctok_pkg::CH_NL)
                        begin
                            r.em0 = mk_emit(sctok_pkg::KIND_STRING, s.start, pos, 1'b0,
                                            s.quote, 1'b1);
                            fresh = 1'b1;
                        end
                        else if (!s.escape && c == sctok_pkg::CH_BSLASH)
                        begin
                            r.st.escape = 1'b1;
                        end
                        else if (!s.escape && c == qc)
                        begin
                            r.em0 = mk_emit(sctok_pkg::KIND_STRING, s.start, after, 1'b0,
                                            s.quote, 1'b0);
                            r.st.mode = MODE_IDLE;
                        end
                        else
                        begin
                            r.st.escape = 1'b0;
                        end
                    end
                    default:
                    begin
                        fresh = 1'b1;
                    end
                endcase

                // classify the byte that opens a new token
                if (fresh)
                begin
                    r.st.mode      = MODE_IDLE;
                    r.st.close_cnt = 2'd0;
                    r.st.escape    = 1'b0;
                    r.st.start     = pos;
                    if (sctok_pkg::is_blank(c))
                    begin
                        r.st.mode = MODE_WS;
                    end
                    else if (c == sctok_pkg::CH_NL)
                    begin
                        r.em1 = mk_emit(sctok_pkg::KIND_NL, pos, after, 1'b0,
                                        sctok_pkg::QUOTE_NONE, 1'b0);
                    end
                    else if (c == sctok_pkg::CH_SLASH && n >= 2'd1 &&
                             c1 == sctok_pkg::CH_SLASH)
                    begin
                        r.st.mode      = MODE_LINE;
                        r.st.close_cnt = 2'd1;
                    end
                    else if (c == sctok_pkg::CH_SLASH && n >= 2'd1 &&
                             c1 == sctok_pkg::CH_STAR)
                    begin
                        r.st.mode      = MODE_BLOCK;
                        r.st.close_cnt = 2'd1;
                    end
                    else if (sctok_pkg::ident_start(c))
                    begin
                        r.st.mode = MODE_IDENT;
                    end
                    else if (sctok_pkg::is_digit(c) ||
                             (c == sctok_pkg::CH_DOT && n >= 2'd1 && sctok_pkg::is_digit(c1)))
                    begin
                        r.st.mode = MODE_NUM;
                    end
                    else if (qk != sctok_pkg::QUOTE_NONE)
                    begin
                        r.st.quote = qk;
                        if (n == 2'd2 && c1 == c && c2 == c)
                        begin
                            r.st.mode      = MODE_TRIPLE;
                            r.st.close_cnt = 2'd2;
                        end
                        else
                        begin
                            r.st.mode = MODE_SINGLE;
                        end
                    end
                    else
                    begin
                        r.em1 = mk_emit(sctok_pkg::KIND_SYMBOL, pos, after, 1'b0,
                                        sctok_pkg::QUOTE_NONE, 1'b0);
                    end
                end
            end
            r.st.pos = after;
        end
        return r;
    endfunction

    // token still open at end of text
    function automatic emit_t flush_emit(input lex_state_t s);
        emit_t r;
        r = '0;
        case (s.mode)
            MODE_WS:
                r = mk_emit(sctok_pkg::KIND_WS, s.start, s.pos, 1'b0,
                            sctok_pkg::QUOTE_NONE, 1'b0);
            MODE_LINE, MODE_BLOCK_END:
                r = mk_emit(sctok_pkg::KIND_COMMENT, s.start, s.pos, 1'b0,
                            sctok_pkg::QUOTE_NONE, 1'b0);
            MODE_BLOCK:
                r = mk_emit(sctok_pkg::KIND_COMMENT, s.start, s.pos, 1'b0,
                            sctok_pkg::QUOTE_NONE, 1'b1);
            MODE_IDENT:
                r = mk_emit(sctok_pkg::KIND_IDENT, s.start, s.pos, 1'b0,
                            sctok_pkg::QUOTE_NONE, 1'b0);
            MODE_NUM:
                r = mk_emit(sctok_pkg::KIND_NUM, s.start, s.pos, 1'b0,
                            sctok_pkg::QUOTE_NONE, 1'b0);
            MODE_TRIPLE:
                r = mk_emit(sctok_pkg::KIND_STRING, s.start, s.pos, 1'b1, s.quote, 1'b1);
            MODE_TRIPLE_END:
                r = mk_emit(sctok_pkg::KIND_STRING, s.start, s.pos, 1'b1, s.quote, 1'b0);
            MODE_SINGLE:
                r = mk_emit(sctok_pkg::KIND_STRING, s.start, s.pos, 1'b0, s.quote, 1'b1);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // registers
    logic                                skip_reg;
    lex_state_t                          lex_reg;
    lex_state_t                          lex_next;
    logic [7:0]                          held_reg [2];
    logic [1:0]                          held_cnt_reg;
    logic [1:0]                          held_cnt_next;
    logic [sctok_pkg::COUNT_W-1:0]       te_reg;
    logic [sctok_pkg::COUNT_W-1:0]       te_next;
    res_t                                res_reg [sctok_pkg::MAX_RESULTS];
    logic [RES_CNT_W-1:0]                res_cnt_reg;
    logic [RES_CNT_W-1:0]                res_cnt_next;

    // datapath signals
    logic                                acc;
    logic                                pop;
    logic                                fin;
    logic [7:0]                          in_byte;
    logic [7:0]                          win0;
    logic [7:0]                          win1;
    logic [7:0]                          win2;
    logic [1:0]                          win_len;
    logic                                act0;
    logic                                act1;
    logic                                act2;
    lex_out_t                            s0;
    lex_out_t                            s1;
    lex_out_t                            s2;
    emit_t                               cand [NUM_CAND];
    emit_t                               slot_em [sctok_pkg::MAX_RESULTS];
    logic [2:0]                          kept_cnt;
    logic [RES_CNT_W-1:0]                n_out;
    res_t                                slot_res [sctok_pkg::MAX_RESULTS];
    logic [sctok_pkg::COUNT_W:0]         te_sum;
    logic                                cfg_wr;

    assign fin     = byte_in.final_byte;
    assign in_byte = byte_in.text_byte;
    assign pop     = token_out.valid & token_out.ready;
    assign acc     = byte_in.valid & byte_in.ready;

    // input is taken while the result buffer is empty or empties this cycle
    assign byte_in.ready = (res_cnt_reg == RES_CNT_W'(0)) ||
                           ((res_cnt_reg == RES_CNT_W'(1)) && token_out.ready);

    // lexing window: held bytes then the new byte
    always_comb
    begin
        win0    = in_byte;
        win1    = 8'h00;
        win2    = 8'h00;
        win_len = 2'd1;
        case (held_cnt_reg)
            2'd1:
            begin
                win0    = held_reg[0];
                win1    = in_byte;
                win_len = 2'd2;
            end
            2'd2:
            begin
                win0    = held_reg[0];
                win1    = held_reg[1];
                win2    = in_byte;
                win_len = 2'd3;
            end
            default:
            begin
                win0    = in_byte;
                win_len = 2'd1;
            end
        endcase
    end

    assign act0 = fin || (held_cnt_reg == 2'd2);
    assign act1 = fin && (win_len >= 2'd2);
    assign act2 = fin && (win_len == 2'd3);

    // chained lexing steps
    assign s0 = lex_step(lex_reg, act0, win0, win_len - 2'd1, win1, win2);
    assign s1 = lex_step(s0.st, act1, win1, win_len - 2'd2, win2, 8'h00);
    assign s2 = lex_step(s1.st, act2, win2, 2'd0, 8'h00, 8'h00);

    // candidate tokens in emission order
    always_comb
    begin
        cand[0] = s0.em0;
        cand[1] = s0.em1;
        cand[2] = s1.em0;
        cand[3] = s1.em1;
        cand[4] = s2.em0;
        cand[5] = s2.em1;
        cand[6] = fin ? flush_emit(s2.st) : '0;
    end

    // drop blank tokens when skipping and pack the rest into result slots
    always_comb
    begin
        kept_cnt = 3'd0;
        for (int j = 0; j < sctok_pkg::MAX_RESULTS; j++)
        begin
            slot_em[j] = '0;
        end
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (cand[i].vld && !(skip_reg && (cand[i].kind == sctok_pkg::KIND_WS ||
                                              cand[i].kind == sctok_pkg::KIND_NL)))
            begin
                if (kept_cnt < 3'(sctok_pkg::MAX_RESULTS))
                begin
                    slot_em[kept_cnt[1:0]] = cand[i];
                end
                kept_cnt = kept_cnt + 3'd1;
            end
        end
        n_out = (kept_cnt > 3'(sctok_pkg::MAX_RESULTS)) ?
                RES_CNT_W'(sctok_pkg::MAX_RESULTS) : RES_CNT_W'(kept_cnt);
    end

    // result fields for each slot
    always_comb
    begin
        for (int j = 0; j < sctok_pkg::MAX_RESULTS; j++)
        begin
            logic [sctok_pkg::COUNT_W:0] num;
            pos_t                        len;
            num = {1'b0, te_reg} + (sctok_pkg::COUNT_W + 1)'(j + 1);
            len = (slot_em[j].stop > slot_em[j].start) ?
                  slot_em[j].stop - slot_em[j].start : OFFSET_BITS'(1);
            slot_res[j].kind   = slot_em[j].kind;
            slot_res[j].offset = clamp32(slot_em[j].start);
            slot_res[j].length = clamp32(len);
            slot_res[j].trip   = slot_em[j].trip;
            slot_res[j].qk     = slot_em[j].qk;
            slot_res[j].broken = slot_em[j].broken;
            slot_res[j].number = num[sctok_pkg::COUNT_W] ? '1 : num[sctok_pkg::COUNT_W-1:0];
            slot_res[j].last   = (RES_CNT_W'(j + 1) == n_out);
            slot_res[j].done   = fin && (RES_CNT_W'(j + 1) == n_out);
        end
    end

    // token counter, saturating, cleared by a final byte
    assign te_sum  = {1'b0, te_reg} + (sctok_pkg::COUNT_W + 1)'(n_out);
    assign te_next = fin ? '0 :
                     (te_sum[sctok_pkg::COUNT_W] ? '1 : te_sum[sctok_pkg::COUNT_W-1:0]);

    // lexer state and held count after the request
    always_comb
    begin
        lex_next      = lex_reg;
        held_cnt_next = held_cnt_reg;
        if (fin)
        begin
            lex_next      = LEX_RESET;
            held_cnt_next = 2'd0;
        end
        else if (held_cnt_reg == 2'd2)
        begin
            lex_next = s2.st;
        end
        else
        begin
            held_cnt_next = held_cnt_reg + 2'd1;
        end
    end

    // buffer fill level
    always_comb
    begin
        if (acc)
        begin
            res_cnt_next = n_out;
        end
        else if (pop)
        begin
            res_cnt_next = res_cnt_reg - RES_CNT_W'(1);
        end
        else
        begin
            res_cnt_next = res_cnt_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_reg      <= LEX_RESET;
            held_cnt_reg <= 2'd0;
            te_reg       <= '0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (acc)
            begin
                lex_reg      <= lex_next;
                held_cnt_reg <= held_cnt_next;
                te_reg       <= te_next;
            end
        end
    end

    // held lookahead bytes
    always_ff @(posedge clk)
    begin
        if (acc && !fin)
        begin
            if (held_cnt_reg == 2'd2)
            begin
                held_reg[0] <= held_reg[1];
                held_reg[1] <= in_byte;
            end
            else
            begin
                held_reg[held_cnt_reg[0]] <= in_byte;
            end
        end
    end

    // result buffer: load on request, shift on each taken result
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int j = 0; j < sctok_pkg::MAX_RESULTS; j++)
            begin
                res_reg[j] <= slot_res[j];
            end
        end
        else if (pop)
        begin
            for (int j = 0; j < sctok_pkg::MAX_RESULTS - 1; j++)
            begin
                res_reg[j] <= res_reg[j + 1];
            end
        end
    end

    // output channel
    assign token_out.valid        = (res_cnt_reg != RES_CNT_W'(0));
    assign token_out.token_kind   = res_reg[0].kind;
    assign token_out.token_offset = res_reg[0].offset;
    assign token_out.token_length = res_reg[0].length;
    assign token_out.is_triplet   = res_reg[0].trip;
    assign token_out.quote_kind   = res_reg[0].qk;
    assign token_out.is_broken    = res_reg[0].broken;
    assign token_out.token_number = res_reg[0].number;
    assign token_out.text_done    = res_reg[0].done;
    assign token_out.last_of_run  = res_reg[0].last;

    // configuration register
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[sctok_pkg::CFG_ADDR_W-1:2] == sctok_pkg::REG_SKIP_BLANK) ?
                    sctok_pkg::CFG_DATA_W'(skip_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b1;
        end
        else if (cfg_wr && paddr[sctok_pkg::CFG_ADDR_W-1:2] == sctok_pkg::REG_SKIP_BLANK)
        begin
            skip_reg <= pwdata[0];
        end
    end

endmodule

`default_nettype wire
